// ===== rtl/fmbp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmbp_pkg
// Shared types and constants for the metadata block header parser.
// ----------------------------------------------------------------------------
package fmbp_pkg;

  // parse phase
  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_HDR  = 3'd1,
    PH_DATA = 3'd2,
    PH_DONE = 3'd3,
    PH_BAD  = 3'd4
  } phase_e;

  localparam logic [31:0] SIGNATURE     = 32'h664C_6143;  // "fLaC"
  localparam logic [23:0] STREAMINFO_MIN = 24'd34;
  localparam logic [6:0]  TYPE_STREAMINFO = 7'd0;
  localparam logic [23:0] SIG_LAST_IDX  = 24'd3;   // 4-byte signature
  localparam logic [23:0] HDR_LAST_IDX  = 24'd3;   // 4-byte header
  localparam logic [23:0] INFO_FIRST    = 24'd10;  // captured data bytes 10..17
  localparam logic [23:0] INFO_LAST     = 24'd17;

  localparam logic STATUS_BLOCK   = 1'b0;
  localparam logic STATUS_BAD_SIG = 1'b1;

  // one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  // raw record of a completed block, before decode
  typedef struct packed {
    logic        status;
    logic [6:0]  block_type;
    logic [23:0] block_length;
    logic        is_last_block;
    logic [63:0] capture;
  } blk_rec_t;

  // decoded result request
  typedef struct packed {
    logic        status;
    logic [6:0]  block_type;
    logic [23:0] block_length;
    logic        is_last_block;
    logic        info_valid;
    logic [19:0] sample_rate;
    logic [3:0]  channel_count;
    logic [5:0]  sample_bits;
    logic [35:0] total_samples;
  } result_t;

endpackage

// ===== rtl/fmbp_in_stage.sv =====
// ----------------------------------------------------------------------------
// fmbp_in_stage
// Input register for byte requests; holds one request until the parser takes it.
// ----------------------------------------------------------------------------
module fmbp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fmbp_pkg::in_item_t in_item_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output fmbp_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  fmbp_pkg::in_item_t item_q, item_d;
  logic               load;

  // register is free when empty or its request is consumed this cycle
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = in_valid_i;
      item_d  = in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/fmbp_parser.sv =====
// ----------------------------------------------------------------------------
// fmbp_parser
// Signature check, header walk and data byte count; one byte per fire.
// ----------------------------------------------------------------------------
module fmbp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  fmbp_pkg::in_item_t item_i,
  output logic               emit_o,
  output fmbp_pkg::blk_rec_t rec_o
);

  fmbp_pkg::phase_e phase_q, phase_d, ph;
  logic [23:0] idx_q, idx_d, idx;
  logic [6:0]  type_q, type_d, typ;
  logic [23:0] len_q, len_d, len;
  logic        last_q, last_d, lst;
  logic [63:0] cap_q, cap_d, cap;
  logic [24:0] idx_inc;
  logic [31:0] sig_word;
  logic [7:0]  b;

  always_comb begin
    // file_start restarts from the reset state
    ph  = item_i.file_start ? fmbp_pkg::PH_SIG : phase_q;
    idx = item_i.file_start ? '0 : idx_q;
    typ = item_i.file_start ? '0 : type_q;
    len = item_i.file_start ? '0 : len_q;
    lst = item_i.file_start ? 1'b0 : last_q;
    cap = item_i.file_start ? '0 : cap_q;
    b   = item_i.data_byte;

    idx_inc  = {1'b0, idx} + 25'd1;
    sig_word = {cap[23:0], b};

    phase_d = ph;
    idx_d   = idx;
    type_d  = typ;
    len_d   = len;
    last_d  = lst;
    cap_d   = cap;
    emit_o  = 1'b0;
    rec_o   = '0;

    case (ph)
      fmbp_pkg::PH_SIG: begin
        cap_d = {32'd0, sig_word};
        idx_d = idx_inc[23:0];
        if (idx == fmbp_pkg::SIG_LAST_IDX) begin
          idx_d = '0;
          cap_d = '0;
          if (sig_word == fmbp_pkg::SIGNATURE) begin
            phase_d = fmbp_pkg::PH_HDR;
          end else begin
            phase_d      = fmbp_pkg::PH_BAD;
            emit_o       = 1'b1;
            rec_o.status = fmbp_pkg::STATUS_BAD_SIG;
          end
        end
      end
      fmbp_pkg::PH_HDR: begin
        if (idx == '0) begin
          last_d = b[7];
          type_d = b[6:0];
          len_d  = '0;
        end else begin
          len_d = {len[15:0], b};
        end
        idx_d = idx_inc[23:0];
        if (idx == fmbp_pkg::HDR_LAST_IDX) begin
          idx_d = '0;
          cap_d = '0;
          if (len_d == '0) begin
            // empty block completes on its last header byte
            emit_o  = 1'b1;
            phase_d = last_d ? fmbp_pkg::PH_DONE : fmbp_pkg::PH_HDR;
          end else begin
            phase_d = fmbp_pkg::PH_DATA;
          end
        end
      end
      fmbp_pkg::PH_DATA: begin
        if (idx inside {[fmbp_pkg::INFO_FIRST:fmbp_pkg::INFO_LAST]}) begin
          cap_d = {cap[55:0], b};
        end
        if (idx_inc >= {1'b0, len}) begin
          emit_o  = 1'b1;
          idx_d   = '0;
          phase_d = lst ? fmbp_pkg::PH_DONE : fmbp_pkg::PH_HDR;
        end else begin
          idx_d = idx_inc[23:0];
        end
      end
      default: begin
        // done or bad signature: ignore until file_start
      end
    endcase

    if (emit_o && (ph != fmbp_pkg::PH_SIG)) begin
      rec_o.status        = fmbp_pkg::STATUS_BLOCK;
      rec_o.block_type    = type_d;
      rec_o.block_length  = len_d;
      rec_o.is_last_block = last_d;
      rec_o.capture       = cap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fmbp_pkg::PH_SIG;
      idx_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      last_q  <= 1'b0;
      cap_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      type_q  <= type_d;
      len_q   <= len_d;
      last_q  <= last_d;
      cap_q   <= cap_d;
    end
  end

endmodule

// ===== rtl/fmbp_info_decode.sv =====
// ----------------------------------------------------------------------------
// fmbp_info_decode
// Unpacks the STREAMINFO fields from the captured bytes of a completed block.
// ----------------------------------------------------------------------------
module fmbp_info_decode (
  input  fmbp_pkg::blk_rec_t rec_i,
  output fmbp_pkg::result_t  res_o
);

  logic [31:0] word;
  logic        ok;

  assign word = rec_i.capture[63:32];
  assign ok   = (rec_i.status == fmbp_pkg::STATUS_BLOCK)
             && (rec_i.block_type == fmbp_pkg::TYPE_STREAMINFO)
             && (rec_i.block_length >= fmbp_pkg::STREAMINFO_MIN);

  always_comb begin
    res_o               = '0;
    res_o.status        = rec_i.status;
    res_o.block_type    = rec_i.block_type;
    res_o.block_length  = rec_i.block_length;
    res_o.is_last_block = rec_i.is_last_block;
    if (ok) begin
      res_o.info_valid    = 1'b1;
      res_o.sample_rate   = word[31:12];
      res_o.channel_count = {1'b0, word[11:9]} + 4'd1;
      res_o.sample_bits   = {1'b0, word[8:4]} + 6'd1;
      res_o.total_samples = {word[3:0], rec_i.capture[31:0]};
    end
  end

endmodule

// ===== rtl/flac_metadata_block_parser_top.sv =====
// ----------------------------------------------------------------------------
// flac_metadata_block_parser_top
// Byte-stream parser for the signature and metadata block headers of a file.
// ----------------------------------------------------------------------------
// Input channel: one file byte per request (data_byte_i, file_start_i) on
//   in_valid_i / in_stall_o. file_start_i marks the first byte of a file and
//   restarts the parse with that byte as signature byte 0.
// Output channel: one result request per completed metadata block, or one with
//   status_o = 1 on the fourth byte of a bad signature, on out_valid_o /
//   out_stall_i. Most bytes give no result.
// Path: an accepted byte lands in the input register; the combinational
//   parse step loads any result into the output register as the byte
//   advances.
// Throughput: one byte per cycle while no result waits on out_stall_i;
//   the parse step between the two registers is combinational.
// Stall: while out_stall_i holds a waiting result, the parser keeps working
//   on bytes that give no result; a byte that gives a result waits in the
//   input register and in_stall_o goes high until the output register frees.
// Reset: both registers empty, parse state back to awaiting the signature.
// ----------------------------------------------------------------------------
module flac_metadata_block_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [6:0]  block_type_o,
  output logic [23:0] block_length_o,
  output logic        is_last_block_o,
  output logic        info_valid_o,
  output logic [19:0] sample_rate_o,
  output logic [3:0]  channel_count_o,
  output logic [5:0]  sample_bits_o,
  output logic [35:0] total_samples_o
);

  fmbp_pkg::in_item_t in_item;
  fmbp_pkg::in_item_t item;
  fmbp_pkg::blk_rec_t rec;
  fmbp_pkg::result_t  res;
  fmbp_pkg::result_t  res_q, res_d;
  logic               item_valid;
  logic               advance;
  logic               emit;
  logic               out_valid_q, out_valid_d;
  logic               out_free;
  logic               out_load;

  assign in_item.data_byte  = data_byte_i;
  assign in_item.file_start = file_start_i;

  fmbp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  // A byte with no result moves whatever the output side does; a byte that
  // gives a result moves only when the output register is empty or draining.
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = item_valid && (out_free || !emit);

  fmbp_parser u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(advance),
    .item_i(item),
    .emit_o(emit),
    .rec_o (rec)
  );

  fmbp_info_decode u_decode (
    .rec_i(rec),
    .res_o(res)
  );

  // output register
  assign out_load = advance && emit;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      res_d       = res;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign block_type_o    = res_q.block_type;
  assign block_length_o  = res_q.block_length;
  assign is_last_block_o = res_q.is_last_block;
  assign info_valid_o    = res_q.info_valid;
  assign sample_rate_o   = res_q.sample_rate;
  assign channel_count_o = res_q.channel_count;
  assign sample_bits_o   = res_q.sample_bits;
  assign total_samples_o = res_q.total_samples;

endmodule
